// ----- sv/fba_pkg.sv -----
`timescale 1ns / 1ps
// fba_pkg: shared constants, types and hole lookup functions of the fragment allocator
// no dependencies; used by fba_hole_eval, fragment_bitmap_allocator_unit and its testbench

package fba_pkg;

    // bitmap geometry
    localparam int BITMAP_BYTES_DEF = 4096;
    localparam int FRAGS_PER_BLOCK  = 4;
    localparam int HOLE_SIZES       = FRAGS_PER_BLOCK;

    // field widths
    localparam int REQ_W   = 2;
    localparam int FRAG_W  = 3;
    localparam int INDEX_W = 12;
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 15;
    localparam int BPC_W   = 9;
    localparam int CYL_W   = 13;
    localparam int CFG_W   = 13;
    localparam int BLK_W   = ADDR_W - 2;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    // register reset values
    localparam logic [BPC_W-1:0] BPC_RESET = 9'd16;
    localparam logic [CYL_W-1:0] CYL_RESET = 13'd1;

    // request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_type_t;

    // configuration register indexes
    localparam logic CFG_BPC = 1'b0;
    localparam logic CFG_CYL = 1'b1;

    // offset code meaning no hole in a nibble
    localparam logic [2:0] NO_HOLE = 3'd4;

    // first hole of exactly 1, 2 or 3 free fragments in each nibble
    localparam logic [2:0] HOLE_AT [16][3] = '{
        '{3'd4, 3'd4, 3'd4}, '{3'd4, 3'd4, 3'd0}, '{3'd3, 3'd0, 3'd4}, '{3'd4, 3'd0, 3'd4},
        '{3'd0, 3'd2, 3'd4}, '{3'd0, 3'd4, 3'd4}, '{3'd0, 3'd4, 3'd4}, '{3'd0, 3'd4, 3'd4},
        '{3'd4, 3'd4, 3'd1}, '{3'd4, 3'd1, 3'd4}, '{3'd1, 3'd4, 3'd4}, '{3'd1, 3'd4, 3'd4},
        '{3'd4, 3'd2, 3'd4}, '{3'd2, 3'd4, 3'd4}, '{3'd3, 3'd4, 3'd4}, '{3'd4, 3'd4, 3'd4}
    };

    // per-size hole hits of one bitmap byte
    typedef struct packed {
        logic [HOLE_SIZES-1:0]      hit;
        logic [HOLE_SIZES-1:0]      lower;
        logic [HOLE_SIZES-1:0][1:0] off;
    } hole_hit_t;

    // offset of a hole of size (size_idx + 1) in a nibble, or NO_HOLE
    function automatic logic [2:0] hole_offset(input logic [3:0] nib, input logic [1:0] size_idx);
        logic [2:0] res;
        if (size_idx == 2'd3) begin
            res = (nib == 4'd0) ? 3'd0 : NO_HOLE;
        end else begin
            res = HOLE_AT[nib][size_idx];
        end
        return res;
    endfunction

    // frags leading bits set from fragment offset off, msb is offset 0
    function automatic logic [3:0] leading_mask(input logic [FRAG_W-1:0] frags,
                                                input logic [1:0] off);
        logic [3:0] top;
        top = 4'b1111 << (3'd4 - frags);
        return top >> off;
    endfunction

endpackage

// ----- sv/fba_ram.sv -----
`timescale 1ns / 1ps
// fba_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module fba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/fba_hole_eval.sv -----
`timescale 1ns / 1ps
// fba_hole_eval: finds the first hole of each size in one bitmap byte
// depends on fba_pkg (hole table, hole_hit_t)

module fba_hole_eval (
    input  logic [fba_pkg::BYTE_W-1:0] bitmap_byte,
    input  logic                       upper_ok,
    input  logic                       lower_ok,
    output fba_pkg::hole_hit_t         hits
);

    // upper block is checked before lower block for every hole size
    always_comb begin
        logic [2:0] up_off;
        logic [2:0] lo_off;
        logic       up_hit;
        logic       lo_hit;
        hits = '0;
        for (int s = 0; s < fba_pkg::HOLE_SIZES; s++) begin
            up_off = fba_pkg::hole_offset(bitmap_byte[7:4], 2'(s));
            lo_off = fba_pkg::hole_offset(bitmap_byte[3:0], 2'(s));
            up_hit = upper_ok && (up_off != fba_pkg::NO_HOLE);
            lo_hit = lower_ok && (lo_off != fba_pkg::NO_HOLE);
            hits.hit[s]   = up_hit || lo_hit;
            hits.lower[s] = !up_hit;
            hits.off[s]   = up_hit ? up_off[1:0] : lo_off[1:0];
        end
    end

endmodule

// ----- sv/fragment_bitmap_allocator_unit.sv -----
`timescale 1ns / 1ps
// fragment_bitmap_allocator_unit: top level, request sequencer, bitmap ram and output register
// depends on fba_pkg, fba_ram, fba_hole_eval

// Best-fit fragment allocator over a block bitmap held in an internal ram of BITMAP_BYTES
// bytes (two 4-fragment blocks per byte, set bit = allocated). Requests arrive on the s_
// stream, one result per request leaves on the m_ stream. An allocate request makes one
// pass over the bitmap, one ram read per byte through the single read port, and keeps the
// first hole of each size; the pass reads N bytes, where N is the smaller of
// BITMAP_BYTES and data_cylinders * ((blocks_per_cylinder + 1) / 2). The block takes
// one request at a time; a finished result waits in the output register while the next
// request is taken. Bitmap contents are undefined until written: load every byte that
// an allocation will scan before allocating. Configuration writes are meant only while
// the block is idle.

module fragment_bitmap_allocator_unit #(
    parameter int BITMAP_BYTES = fba_pkg::BITMAP_BYTES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // request stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // frag_count [2:0], byte_index [14:3], byte_value [22:15], zero [23]
    input  logic [fba_pkg::S_DATA_W-1:0] s_tdata,
    // req_type [1:0]
    input  logic [fba_pkg::REQ_W-1:0]    s_tuser,
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // found [0], frag_address [15:1], read_byte [23:16], bad_request [24], zero [31:25]
    output logic [fba_pkg::M_DATA_W-1:0] m_tdata,
    // configuration write port
    input  logic                         cfg_we,
    input  logic                         cfg_addr,
    input  logic [fba_pkg::CFG_W-1:0]    cfg_wdata
);

    localparam int AW = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam int IW = AW + 1;
    localparam logic [IW-1:0] IDX_END = IW'(BITMAP_BYTES);
    localparam int NS = fba_pkg::HOLE_SIZES;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SCAN   = 7'b0000010,
        ST_DRAIN  = 7'b0000100,
        ST_PICK   = 7'b0001000,
        ST_RDWAIT = 7'b0010000,
        ST_RESULT = 7'b0100000,
        ST_SPARE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [fba_pkg::BPC_W-1:0] bpc_reg;
    logic [fba_pkg::CYL_W-1:0] cyl_cnt_reg;

    // request fields
    logic [fba_pkg::FRAG_W-1:0]  in_frags;
    logic [fba_pkg::INDEX_W-1:0] in_index;
    logic [fba_pkg::BYTE_W-1:0]  in_value;
    logic                        in_range;
    logic                        accept;

    assign in_frags = s_tdata[2:0];
    assign in_index = s_tdata[14:3];
    assign in_value = s_tdata[22:15];
    assign in_range = (32'(in_index) < 32'(BITMAP_BYTES));
    assign accept   = s_tvalid && s_tready;

    // scan counters
    logic [fba_pkg::FRAG_W-1:0] frags_reg, frags_next;
    logic [IW-1:0]              idx_reg, idx_next;
    logic [fba_pkg::BPC_W-1:0]  j_reg, j_next;
    logic [fba_pkg::CYL_W-1:0]  cyl_reg, cyl_next;
    logic [fba_pkg::BLK_W-1:0]  blk_reg, blk_next;

    // byte under evaluation, registered in the cycle after its ram address is issued
    logic                       ev_valid_reg, ev_valid_next;
    logic                       ev_upper_ok_reg, ev_upper_ok_next;
    logic                       ev_lower_ok_reg, ev_lower_ok_next;
    logic [AW-1:0]              ev_idx_reg, ev_idx_next;
    logic [fba_pkg::BLK_W-1:0]  ev_blk_reg, ev_blk_next;

    // first hole found for each size
    logic [NS-1:0]              cand_valid_reg, cand_valid_next;
    logic [AW-1:0]              cand_idx_reg   [NS];
    logic [fba_pkg::BYTE_W-1:0] cand_byte_reg  [NS];
    logic                       cand_lower_reg [NS];
    logic [1:0]                 cand_off_reg   [NS];
    logic [fba_pkg::BLK_W-1:0]  cand_blk_reg   [NS];

    // result fields and output register
    logic                        res_found_reg, res_found_next;
    logic [fba_pkg::ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic [fba_pkg::BYTE_W-1:0]  res_rd_reg, res_rd_next;
    logic                        res_bad_reg, res_bad_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [fba_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // ram ports
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [fba_pkg::BYTE_W-1:0] ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [fba_pkg::BYTE_W-1:0] ram_rdata;

    fba_ram #(
        .WIDTH (fba_pkg::BYTE_W),
        .DEPTH (BITMAP_BYTES),
        .AW    (AW)
    ) u_bitmap (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // shared hole finder on the byte just read
    fba_pkg::hole_hit_t hits;

    fba_hole_eval u_eval (
        .bitmap_byte (ram_rdata),
        .upper_ok    (ev_upper_ok_reg),
        .lower_ok    (ev_lower_ok_reg),
        .hits        (hits)
    );

    // cylinder geometry
    logic [fba_pkg::BPC_W-1:0] bytes_per_cyl;
    logic [fba_pkg::BPC_W-1:0] last_j;
    logic                      odd_cyl;
    logic                      j_last;
    logic                      cyl_last;

    assign bytes_per_cyl = fba_pkg::BPC_W'((10'(bpc_reg) + 10'd1) >> 1);
    assign last_j        = bytes_per_cyl - 9'd1;
    assign odd_cyl       = bpc_reg[0];
    assign j_last        = (j_reg == last_j);
    assign cyl_last      = ((14'(cyl_reg) + 14'd1) == 14'(cyl_cnt_reg));

    // smallest hole size that fits the request
    logic                      pick_ok;
    logic [1:0]                pick_s;
    logic [3:0]                pick_mask;
    logic [fba_pkg::BYTE_W-1:0] pick_byte;

    always_comb begin
        pick_ok = 1'b0;
        pick_s  = 2'd0;
        for (int s = NS - 1; s >= 0; s--) begin
            if (cand_valid_reg[s] && ((3'(s) + 3'd1) >= frags_reg)) begin
                pick_ok = 1'b1;
                pick_s  = 2'(s);
            end
        end
        pick_mask = fba_pkg::leading_mask(frags_reg, cand_off_reg[pick_s]);
        pick_byte = cand_lower_reg[pick_s] ? (cand_byte_reg[pick_s] | {4'd0, pick_mask})
                                           : (cand_byte_reg[pick_s] | {pick_mask, 4'd0});
    end

    assign s_tready = (state_reg == ST_IDLE);

    // request sequencer
    always_comb begin
        state_next       = state_reg;
        frags_next       = frags_reg;
        idx_next         = idx_reg;
        j_next           = j_reg;
        cyl_next         = cyl_reg;
        blk_next         = blk_reg;
        ev_valid_next    = 1'b0;
        ev_upper_ok_next = ev_upper_ok_reg;
        ev_lower_ok_next = ev_lower_ok_reg;
        ev_idx_next      = ev_idx_reg;
        ev_blk_next      = ev_blk_reg;
        cand_valid_next  = cand_valid_reg;
        res_found_next   = res_found_reg;
        res_addr_next    = res_addr_reg;
        res_rd_next      = res_rd_reg;
        res_bad_next     = res_bad_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        ram_we           = 1'b0;
        ram_waddr        = AW'(in_index);
        ram_wdata        = in_value;
        ram_raddr        = AW'(in_index);

        // result taken downstream
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // record the first hole of each size
        if (ev_valid_reg) begin
            for (int s = 0; s < NS; s++) begin
                if (hits.hit[s] && !cand_valid_reg[s]) begin
                    cand_valid_next[s] = 1'b1;
                end
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_found_next = 1'b0;
                    res_addr_next  = '0;
                    res_rd_next    = '0;
                    res_bad_next   = 1'b0;
                    frags_next     = in_frags;
                    idx_next       = '0;
                    j_next         = '0;
                    cyl_next       = '0;
                    blk_next       = '0;
                    cand_valid_next = '0;
                    case (fba_pkg::req_type_t'(s_tuser))
                        fba_pkg::REQ_ALLOC: begin
                            if (in_frags < 3'd1 || in_frags > 3'(fba_pkg::FRAGS_PER_BLOCK)) begin
                                res_bad_next = 1'b1;
                                state_next   = ST_RESULT;
                            end else if (bpc_reg == '0 || cyl_cnt_reg == '0) begin
                                state_next = ST_PICK;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        fba_pkg::REQ_WRITE: begin
                            ram_we     = in_range;
                            state_next = ST_RESULT;
                        end
                        fba_pkg::REQ_READ: begin
                            state_next = in_range ? ST_RDWAIT : ST_RESULT;
                        end
                        default: begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // issue one byte read and step the cylinder counters
                ram_raddr        = idx_reg[AW-1:0];
                ev_valid_next    = 1'b1;
                ev_upper_ok_next = (cyl_reg != '0) || (j_reg != '0);
                ev_lower_ok_next = !(j_last && odd_cyl);
                ev_idx_next      = idx_reg[AW-1:0];
                ev_blk_next      = blk_reg;
                idx_next         = idx_reg + 1'b1;
                if (j_last) begin
                    j_next   = '0;
                    cyl_next = cyl_reg + 1'b1;
                    blk_next = blk_reg + (odd_cyl ? 13'd1 : 13'd2);
                end else begin
                    j_next   = j_reg + 1'b1;
                    blk_next = blk_reg + 13'd2;
                end
                if ((idx_next == IDX_END) || (j_last && cyl_last)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_PICK;
            end
            ST_PICK: begin
                // mark the chosen fragments and build the address
                if (pick_ok) begin
                    ram_we         = 1'b1;
                    ram_waddr      = cand_idx_reg[pick_s];
                    ram_wdata      = pick_byte;
                    res_found_next = 1'b1;
                    res_addr_next  = {cand_blk_reg[pick_s], cand_off_reg[pick_s]};
                end
                state_next = ST_RESULT;
            end
            ST_RDWAIT: begin
                res_rd_next = ram_rdata;
                state_next  = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'd0, res_bad_reg, res_rd_reg, res_addr_reg, res_found_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ev_valid_reg   <= 1'b0;
            cand_valid_reg <= '0;
            m_tvalid_reg   <= 1'b0;
            bpc_reg        <= fba_pkg::BPC_RESET;
            cyl_cnt_reg    <= fba_pkg::CYL_RESET;
        end else begin
            state_reg      <= state_next;
            ev_valid_reg   <= ev_valid_next;
            cand_valid_reg <= cand_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    fba_pkg::CFG_BPC: bpc_reg     <= cfg_wdata[fba_pkg::BPC_W-1:0];
                    fba_pkg::CFG_CYL: cyl_cnt_reg <= cfg_wdata[fba_pkg::CYL_W-1:0];
                    default: begin
                        bpc_reg <= bpc_reg;
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        frags_reg       <= frags_next;
        idx_reg         <= idx_next;
        j_reg           <= j_next;
        cyl_reg         <= cyl_next;
        blk_reg         <= blk_next;
        ev_upper_ok_reg <= ev_upper_ok_next;
        ev_lower_ok_reg <= ev_lower_ok_next;
        ev_idx_reg      <= ev_idx_next;
        ev_blk_reg      <= ev_blk_next;
        res_found_reg   <= res_found_next;
        res_addr_reg    <= res_addr_next;
        res_rd_reg      <= res_rd_next;
        res_bad_reg     <= res_bad_next;
        m_tdata_reg     <= m_tdata_next;
        // candidate details follow their valid bits
        for (int s = 0; s < NS; s++) begin
            if (ev_valid_reg && hits.hit[s] && !cand_valid_reg[s]) begin
                cand_idx_reg[s]   <= ev_idx_reg;
                cand_byte_reg[s]  <= ram_rdata;
                cand_lower_reg[s] <= hits.lower[s];
                cand_off_reg[s]   <= hits.off[s];
                cand_blk_reg[s]   <= ev_blk_reg + {12'd0, hits.lower[s]};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- verif/fragment_bitmap_allocator_unit_tb.sv -----
`timescale 1ns / 1ps
// fragment_bitmap_allocator_unit_tb: self-checking bench for the best-fit fragment allocator
// predicts every answer from a shadow bitmap and checks the result stream in order
// depends on fba_pkg and fragment_bitmap_allocator_unit

module fragment_bitmap_allocator_unit_tb;

    localparam int unsigned MAP_BYTES = fba_pkg::BITMAP_BYTES_DEF;
    localparam int unsigned NO_RUN    = 4;

    // one answer as it leaves on m_tdata, lowest field last
    typedef struct packed {
        logic [6:0]                 pad;
        logic                       bad;
        logic [fba_pkg::BYTE_W-1:0] rbyte;
        logic [fba_pkg::ADDR_W-1:0] addr;
        logic                       found;
    } answer_t;

    logic                         aclk;
    logic                         aresetn   = 1'b0;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [fba_pkg::S_DATA_W-1:0] s_tdata   = '0;
    logic [fba_pkg::REQ_W-1:0]    s_tuser   = '0;
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [fba_pkg::M_DATA_W-1:0] m_tdata;
    logic                         cfg_we    = 1'b0;
    logic                         cfg_addr  = fba_pkg::CFG_BPC;
    logic [fba_pkg::CFG_W-1:0]    cfg_wdata = '0;

    int unsigned sent           = 0;
    int unsigned settings       = 1;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // shadow of the allocator: bitmap, geometry and answers still owed
    class allocation_scoreboard;
        bit [7:0]    shadow_bitmap [MAP_BYTES];
        bit          written [MAP_BYTES];
        int unsigned written_list [$];
        int unsigned blocks_per_cyl = 16;
        int unsigned cylinders      = 1;
        answer_t     owed [$];
        int unsigned errors = 0, checked = 0, granted = 0, disk_full = 0, bad_counts = 0;

        function void set_geometry(int unsigned blocks, int unsigned cyls);
            blocks_per_cyl = blocks & 'h1ff;
            cylinders      = cyls & 'h1fff;
        endfunction

        // offset of the first free run of exactly size fragments, msb is offset 0
        function int unsigned first_hole(logic [3:0] nib, int unsigned size);
            int unsigned run, start, p;
            run = 0;
            start = 0;
            for (p = 0; p <= 4; p++) begin
                if (p < 4 && !nib[3 - p]) begin
                    if (run == 0) start = p;
                    run++;
                end else begin
                    if (run == size) return start;
                    run = 0;
                end
            end
            return NO_RUN;
        endfunction

        function logic [3:0] run_mask(int unsigned frags, int unsigned off);
            int unsigned ones;
            ones = (1 << frags) - 1;
            return 4'(ones << (4 - off - frags));
        endfunction

        // smallest fitting hole first, bytes in order, even block before odd
        function bit best_fit_alloc(int unsigned frags,
                                    output logic [fba_pkg::ADDR_W-1:0] addr);
            int unsigned per_cyl, idx, c, j, size, blk, off;
            bit odd;
            per_cyl = (blocks_per_cyl + 1) / 2;
            odd = blocks_per_cyl[0];
            addr = '0;
            for (size = frags; size <= 4; size++) begin
                idx = 0;
                for (c = 0; c < cylinders && idx < MAP_BYTES; c++) begin
                    for (j = 0; j < per_cyl && idx < MAP_BYTES; j++) begin
                        // block zero is never handed out
                        if (c + j != 0) begin
                            off = first_hole(shadow_bitmap[idx][7:4], size);
                            if (off != NO_RUN) begin
                                shadow_bitmap[idx] = shadow_bitmap[idx]
                                                     | {run_mask(frags, off), 4'h0};
                                blk = c * blocks_per_cyl + 2 * j;
                                addr = fba_pkg::ADDR_W'(blk * 4 + off);
                                return 1'b1;
                            end
                        end
                        // odd cylinder size: last byte has no odd block
                        if (!(odd && j == per_cyl - 1)) begin
                            off = first_hole(shadow_bitmap[idx][3:0], size);
                            if (off != NO_RUN) begin
                                shadow_bitmap[idx] = shadow_bitmap[idx]
                                                     | {4'h0, run_mask(frags, off)};
                                blk = c * blocks_per_cyl + 2 * j + 1;
                                addr = fba_pkg::ADDR_W'(blk * 4 + off);
                                return 1'b1;
                            end
                        end
                        idx++;
                    end
                end
            end
            return 1'b0;
        endfunction

        function void note_request(fba_pkg::req_type_t kind,
                                   logic [fba_pkg::FRAG_W-1:0] frags,
                                   logic [fba_pkg::INDEX_W-1:0] idx,
                                   logic [fba_pkg::BYTE_W-1:0] val);
            answer_t ans;
            logic [fba_pkg::ADDR_W-1:0] addr;
            ans = '0;
            case (kind)
                fba_pkg::REQ_ALLOC: begin
                    if (frags < 1 || frags > fba_pkg::FRAGS_PER_BLOCK) begin
                        ans.bad = 1'b1;
                        bad_counts++;
                    end else if (best_fit_alloc(frags, addr)) begin
                        ans.found = 1'b1;
                        ans.addr  = addr;
                        granted++;
                    end else begin
                        disk_full++;
                    end
                end
                fba_pkg::REQ_WRITE: begin
                    shadow_bitmap[idx] = val;
                    if (!written[idx]) begin
                        written[idx] = 1'b1;
                        written_list.push_back(idx);
                    end
                end
                fba_pkg::REQ_READ: ans.rbyte = shadow_bitmap[idx];
                default: ;
            endcase
            owed.push_back(ans);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [fba_pkg::M_DATA_W-1:0] data);
            answer_t want, got;
            got = answer_t'(data);
            if (owed.size() == 0) begin
                errors++;
                $display("%0t: result %h arrived with no request outstanding", $time, data);
                return;
            end
            want = owed.pop_front();
            checked++;
            compare_field("found", want.found, got.found);
            compare_field("frag_address", want.addr, got.addr);
            compare_field("read_byte", want.rbyte, got.rbyte);
            compare_field("bad_request", want.bad, got.bad);
            compare_field("padding", want.pad, got.pad);
        endfunction
    endclass

    allocation_scoreboard book = new();

    fragment_bitmap_allocator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: check accepted answers, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) book.check_result(m_tdata);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // one request through the s_ handshake, idle pattern rotates every dozen requests
    task automatic issue_request(input fba_pkg::req_type_t kind,
                                 input logic [fba_pkg::FRAG_W-1:0] frags,
                                 input logic [fba_pkg::INDEX_W-1:0] idx,
                                 input logic [fba_pkg::BYTE_W-1:0] val);
        case ((sent / 12) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
        endcase
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, val, idx, frags};
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        book.note_request(kind, frags, idx, val);
        sent++;
    endtask

    // hold requests until every owed answer is back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (book.owed.size() != 0);
    endtask

    // geometry change while idle, both registers every time
    task automatic program_geometry(input int unsigned blocks, input int unsigned cyls);
        wait_for_results();
        repeat (8) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= fba_pkg::CFG_BPC;
        cfg_wdata <= fba_pkg::CFG_W'(blocks);
        @(posedge aclk);
        cfg_addr  <= fba_pkg::CFG_CYL;
        cfg_wdata <= fba_pkg::CFG_W'(cyls);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
        book.set_geometry(blocks, cyls);
        settings++;
    endtask

    // load every byte the next scans will touch
    task automatic preload_bitmap(input int unsigned nbytes);
        int unsigned i;
        for (i = 0; i < nbytes; i++)
            issue_request(fba_pkg::REQ_WRITE, '0, fba_pkg::INDEX_W'(i),
                          8'($urandom) | 8'($urandom));
    endtask

    // mixed traffic over a loaded bitmap of scan_bytes bytes
    task automatic random_traffic(input int unsigned count, input int unsigned scan_bytes);
        int unsigned k, pick;
        logic [fba_pkg::FRAG_W-1:0]  frags;
        logic [fba_pkg::INDEX_W-1:0] idx;
        logic [fba_pkg::BYTE_W-1:0]  val;
        for (k = 0; k < count; k++) begin
            pick  = $urandom_range(99);
            frags = fba_pkg::FRAG_W'($urandom_range(4, 1));
            idx   = fba_pkg::INDEX_W'($urandom);
            val   = fba_pkg::BYTE_W'($urandom);
            if (pick < 45) begin
                issue_request(fba_pkg::REQ_ALLOC, frags, idx, val);
            end else if (pick < 50) begin
                // counts outside one to four
                frags = fba_pkg::FRAG_W'($urandom_range(3));
                if (frags != 0) frags = frags + 3'd4;
                issue_request(fba_pkg::REQ_ALLOC, frags, idx, val);
            end else if (pick < 53) begin
                issue_request(fba_pkg::REQ_NONE, fba_pkg::FRAG_W'($urandom), idx, val);
            end else if (pick < 80) begin
                // mostly bytes in the scanned range, biased toward allocated fragments
                if (scan_bytes != 0 && $urandom_range(9) < 7)
                    idx = fba_pkg::INDEX_W'($urandom_range(scan_bytes - 1));
                case ($urandom_range(3))
                    0: ;
                    1: val = val | 8'($urandom);
                    2: val = 8'hff;
                    default: val = val | 8'($urandom) | 8'($urandom);
                endcase
                issue_request(fba_pkg::REQ_WRITE, frags, idx, val);
            end else begin
                idx = fba_pkg::INDEX_W'(
                    book.written_list[$urandom_range(book.written_list.size() - 1)]);
                issue_request(fba_pkg::REQ_READ, frags, idx, val);
            end
            if ($urandom_range(24) == 0 || k == count / 2) wait_for_results();
        end
    endtask

    initial begin
        int unsigned i, k;
        logic [fba_pkg::INDEX_W-1:0] holes [4];

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset geometry, eight bytes: block zero free but off limits, holes of each size
        issue_request(fba_pkg::REQ_WRITE, '0, 0, 8'h0f);
        issue_request(fba_pkg::REQ_WRITE, '0, 1, 8'hff);
        issue_request(fba_pkg::REQ_WRITE, '0, 2, 8'he1);
        issue_request(fba_pkg::REQ_WRITE, '0, 3, 8'h49);
        issue_request(fba_pkg::REQ_WRITE, '0, 4, 8'hf0);
        issue_request(fba_pkg::REQ_WRITE, '0, 5, 8'hff);
        issue_request(fba_pkg::REQ_WRITE, '0, 6, 8'h00);
        issue_request(fba_pkg::REQ_WRITE, '0, 7, 8'hff);
        issue_request(fba_pkg::REQ_WRITE, 3'h7, 12'hfff, 8'h5a);
        issue_request(fba_pkg::REQ_READ, 3'h7, 12'hfff, 8'hff);
        issue_request(fba_pkg::REQ_READ, '0, 0, '0);
        // every count, bad ones included, with junk in the unused fields
        for (i = 0; i < 8; i++)
            issue_request(fba_pkg::REQ_ALLOC, fba_pkg::FRAG_W'(i),
                          fba_pkg::INDEX_W'($urandom), fba_pkg::BYTE_W'($urandom));
        issue_request(fba_pkg::REQ_NONE, 3'h7, 12'hfff, 8'hff);
        for (i = 0; i < 3; i++)
            issue_request(fba_pkg::REQ_ALLOC, 3'd4, '0, '0);
        issue_request(fba_pkg::REQ_READ, '0, 3, '0);
        issue_request(fba_pkg::REQ_READ, '0, 6, '0);

        // odd cylinder size over several cylinders
        program_geometry(3, 5);
        preload_bitmap(10);
        random_traffic(16, 10);

        // one block per cylinder, only even blocks usable
        program_geometry(1, 20);
        preload_bitmap(20);
        random_traffic(16, 20);

        program_geometry(2, 12);
        preload_bitmap(12);
        random_traffic(16, 12);

        // zero registers: nothing scanned
        program_geometry(0, 7);
        random_traffic(8, 0);
        program_geometry(5, 0);
        random_traffic(8, 0);

        // small disk loaded full, a few holes opened, then run out
        program_geometry(4, 2);
        for (i = 0; i < 4; i++)
            issue_request(fba_pkg::REQ_WRITE, fba_pkg::FRAG_W'($urandom),
                          fba_pkg::INDEX_W'(i), 8'hff);
        for (k = 0; k < 2; k++) begin
            holes[k] = fba_pkg::INDEX_W'($urandom_range(3, 1));
            issue_request(fba_pkg::REQ_WRITE, '0, holes[k],
                          fba_pkg::BYTE_W'($urandom_range(254)));
        end
        for (k = 0; k < 3; k++)
            issue_request(fba_pkg::REQ_ALLOC, fba_pkg::FRAG_W'($urandom_range(4, 1)), '0, '0);
        issue_request(fba_pkg::REQ_READ, '0, holes[0], '0);
        // close the last holes, then the disk is full
        for (k = 0; k < 2; k++)
            issue_request(fba_pkg::REQ_WRITE, '0, holes[k], 8'hff);
        issue_request(fba_pkg::REQ_ALLOC, 3'd1, '0, '0);

        wait_for_results();
        repeat (100) @(posedge aclk);

        $display("%0d requests over %0d geometries, %0d answers checked", sent, settings,
                 book.checked);
        $display("%0d allocations granted, %0d disk full, %0d bad counts", book.granted,
                 book.disk_full, book.bad_counts);
        if (book.errors == 0) begin
            $display("fragment_bitmap_allocator_unit_tb: PASS");
        end else begin
            $display("fragment_bitmap_allocator_unit_tb: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(5_000_000);
        $display("timeout with %0d answers outstanding", book.owed.size());
        $display("fragment_bitmap_allocator_unit_tb: FAIL");
        $finish;
    end

endmodule
